@@ design/woac_pkg.sv @@
`timescale 1ns / 1ps

package woac_pkg;

  // remainder unit: one dividend bit per cycle
  localparam int DivSteps = 16;
  localparam int StepCntW = $clog2(DivSteps);
  localparam int DivW     = 12;
  localparam int NumLanes = 3;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OBSTRUCTION = 3'd0,
    CFG_STOP        = 3'd1,
    CFG_AVOID_BASE  = 3'd2,
    CFG_FWD_MIN     = 3'd3,
    CFG_FWD_MAX     = 3'd4,
    CFG_TURN_MOM    = 3'd5
  } cfg_index_t;

  typedef enum logic [1:0] {
    SPEED_STOP   = 2'd0,
    SPEED_SLOW   = 2'd1,
    SPEED_CRUISE = 2'd2
  } speed_mode_t;

  typedef enum logic [1:0] {
    TURN_STRAIGHT = 2'd0,
    TURN_LEFT     = 2'd1,
    TURN_RIGHT    = 2'd2
  } turn_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [15:0] left_range_mm;
    logic [15:0] right_range_mm;
    logic [15:0] avoid_random;
    logic [15:0] forward_random;
    logic [15:0] turn_random;
  } in_item_t;

  typedef struct packed {
    speed_mode_t speed_mode;
    turn_mode_t  turn_mode;
    logic        avoiding;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic last_step;
    logic out_busy;
  } status_t;

endpackage

@@ design/wander_obstacle_avoid_controller_unit.sv @@
`timescale 1ns / 1ps

// Wandering robot controller with front obstacle avoidance. One sensor tick in,
// one command out: speed_mode (stop, slow, cruise), turn_mode (straight, left,
// right) and the avoiding flag. The transfer edge latches the tick, then the
// bit-serial remainder unit reduces the three random words against the avoid
// base, forward span and turn momentum in parallel lanes, and a commit step
// updates the state and loads the output register. The next tick can be taken
// the cycle after that output register is loaded, while the result may still
// wait for the consumer; a commit waits as long as the previous result is still
// unread. Configuration writes through cfg_we / cfg_index / cfg_wdata land at
// once and must only happen while no tick is in flight; indexes beyond the six
// registers are ignored.

module wander_obstacle_avoid_controller_unit import woac_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_item
);

  cmd_t    cmd;
  status_t status;

  // sequencer: idle -> remainder steps -> commit
  woac_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // config registers, remainder lanes, decision state, output register
  woac_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cmd       (cmd),
    .status    (status)
  );

`ifndef SYNTHESIS
  // at most one command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.step, cmd.commit}))
    else $error("more than one datapath command");

  // a transfer starts a tick; no second transfer right behind it
  a_one_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a tick is in flight");

  // a commit never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(out_valid && !out_ready))
    else $error("pending result overwritten");

  // every commit presents a result
  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("commit without result");
`endif

endmodule

@@ design/woac_ctrl.sv @@
`timescale 1ns / 1ps

module woac_ctrl import woac_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CALC;
      end
      ST_CALC: begin
        if (status.last_step) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!status.out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CALC: begin
        cmd.step = 1'b1;
      end
      ST_FINISH: begin
        // hold the result until the output register is free
        cmd.commit = !status.out_busy;
      end
      default: ;
    endcase
  end

endmodule

@@ design/woac_datapath.sv @@
`timescale 1ns / 1ps

module woac_datapath import woac_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  input  in_item_t            in_item,
  input  logic                out_ready,
  output logic                out_valid,
  output out_item_t           out_item,
  input  cmd_t                cmd,
  output status_t             status
);

  // configuration
  logic [15:0] obst_dist_r, stop_dist_r;
  logic [7:0]  avoid_base_r;
  logic [11:0] fwd_min_r, fwd_max_r;
  logic [6:0]  turn_mom_r;

  // tick state
  logic [8:0]  avoid_rem_r;
  logic [11:0] fwd_cnt_r, fwd_tgt_r;
  logic [7:0]  turn_cnt_r, turn_tgt_r;
  turn_mode_t  held_turn_r;
  logic        drawn_r;

  // latched tick and remainder lanes
  logic [15:0]         left_r, right_r;
  logic [15:0]         dvd_r [NumLanes];
  logic [DivW-1:0]     rem_r [NumLanes];
  logic [DivW-1:0]     rem_nxt [NumLanes];
  logic [DivW-1:0]     divisor [NumLanes];
  logic [StepCntW-1:0] step_cnt_r;

  logic       out_valid_r;
  out_item_t  out_item_r;

  // effective divisors; a zero base or momentum acts as one
  logic [7:0]  base_eff;
  logic [6:0]  mom_eff;
  logic        fwd_span_ok;
  logic [11:0] fwd_span;

  assign base_eff    = (avoid_base_r == 8'd0) ? 8'd1 : avoid_base_r;
  assign mom_eff     = (turn_mom_r == 7'd0) ? 7'd1 : turn_mom_r;
  assign fwd_span_ok = fwd_max_r > fwd_min_r;
  assign fwd_span    = fwd_span_ok ? (fwd_max_r - fwd_min_r) : 12'd1;

  assign divisor[0] = {4'd0, base_eff};
  assign divisor[1] = fwd_span;
  assign divisor[2] = {5'd0, mom_eff};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obst_dist_r  <= 16'd200;
      stop_dist_r  <= 16'd500;
      avoid_base_r <= 8'd12;
      fwd_min_r    <= 12'd50;
      fwd_max_r    <= 12'd100;
      turn_mom_r   <= 7'd30;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OBSTRUCTION: obst_dist_r  <= cfg_wdata;
        CFG_STOP:        stop_dist_r  <= cfg_wdata;
        CFG_AVOID_BASE:  avoid_base_r <= cfg_wdata[7:0];
        CFG_FWD_MIN:     fwd_min_r    <= cfg_wdata[11:0];
        CFG_FWD_MAX:     fwd_max_r    <= cfg_wdata[11:0];
        CFG_TURN_MOM:    turn_mom_r   <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // restoring remainder, one bit per lane per step
  always_comb begin
    logic [DivW:0] trial;
    for (int i = 0; i < NumLanes; i++) begin
      trial = {rem_r[i], dvd_r[i][15]};
      if (trial >= {1'b0, divisor[i]}) trial = trial - {1'b0, divisor[i]};
      rem_nxt[i] = trial[DivW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      left_r   <= in_item.left_range_mm;
      right_r  <= in_item.right_range_mm;
      dvd_r[0] <= in_item.avoid_random;
      dvd_r[1] <= in_item.forward_random;
      dvd_r[2] <= in_item.turn_random;
      for (int i = 0; i < NumLanes; i++) rem_r[i] <= '0;
    end else if (cmd.step) begin
      for (int i = 0; i < NumLanes; i++) begin
        rem_r[i] <= rem_nxt[i];
        dvd_r[i] <= {dvd_r[i][14:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_cnt_r <= '0;
    end else if (cmd.load) begin
      step_cnt_r <= '0;
    end else if (cmd.step) begin
      step_cnt_r <= step_cnt_r + StepCntW'(1);
    end
  end

  assign status.last_step = cmd.step && (step_cnt_r == StepCntW'(DivSteps - 1));
  assign status.out_busy  = out_valid_r && !out_ready;

  // decision logic from the finished remainders
  logic [11:0] drawn_fwd;
  logic [7:0]  drawn_turn;
  logic [8:0]  run_len;
  logic [11:0] fwd_tgt_eff;
  logic [7:0]  turn_tgt_eff;
  logic        obstructed, stopped;

  logic [8:0]  avoid_rem_nxt;
  logic [11:0] fwd_cnt_nxt, fwd_tgt_nxt;
  logic [7:0]  turn_cnt_nxt, turn_tgt_nxt;
  turn_mode_t  held_turn_nxt;
  out_item_t   result;

  assign drawn_fwd    = fwd_span_ok ? (fwd_min_r + rem_r[1]) : fwd_min_r;
  assign drawn_turn   = {rem_r[2][6:0], 1'b1} - {1'b0, mom_eff};
  assign run_len      = {1'b0, rem_r[0][7:0]} + {1'b0, base_eff};
  assign fwd_tgt_eff  = drawn_r ? fwd_tgt_r : drawn_fwd;
  assign turn_tgt_eff = drawn_r ? turn_tgt_r : drawn_turn;
  assign obstructed   = (left_r < obst_dist_r) || (right_r < obst_dist_r);
  assign stopped      = (left_r < stop_dist_r) || (right_r < stop_dist_r);

  always_comb begin
    avoid_rem_nxt = avoid_rem_r;
    fwd_cnt_nxt   = fwd_cnt_r;
    fwd_tgt_nxt   = fwd_tgt_eff;
    turn_cnt_nxt  = turn_cnt_r;
    turn_tgt_nxt  = turn_tgt_eff;
    held_turn_nxt = held_turn_r;
    result        = '0;
    if (obstructed || stopped || (avoid_rem_r != 9'd0)) begin
      result.speed_mode = stopped ? SPEED_STOP : SPEED_SLOW;
      result.avoiding   = 1'b1;
      if (avoid_rem_r == 9'd0) begin
        // run length is at least one, so the decrement always applies
        avoid_rem_nxt = run_len - 9'd1;
        held_turn_nxt = (left_r < stop_dist_r) ? TURN_RIGHT : TURN_LEFT;
      end else begin
        avoid_rem_nxt = avoid_rem_r - 9'd1;
      end
      result.turn_mode = held_turn_nxt;
    end else if (fwd_cnt_r == fwd_tgt_eff) begin
      result.speed_mode = SPEED_STOP;
      if (turn_tgt_eff != 8'd0) begin
        if (turn_tgt_eff[7]) begin
          held_turn_nxt = TURN_RIGHT;
          turn_cnt_nxt  = turn_cnt_r - 8'd1;
        end else begin
          held_turn_nxt = TURN_LEFT;
          turn_cnt_nxt  = turn_cnt_r + 8'd1;
        end
      end
      result.turn_mode = held_turn_nxt;
      if (turn_cnt_nxt == turn_tgt_eff) begin
        fwd_cnt_nxt  = '0;
        turn_cnt_nxt = '0;
        fwd_tgt_nxt  = drawn_fwd;
        turn_tgt_nxt = drawn_turn;
      end
    end else begin
      result.speed_mode = SPEED_CRUISE;
      result.turn_mode  = TURN_STRAIGHT;
      held_turn_nxt     = TURN_STRAIGHT;
      fwd_cnt_nxt       = fwd_cnt_r + 12'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avoid_rem_r <= '0;
      fwd_cnt_r   <= '0;
      fwd_tgt_r   <= '0;
      turn_cnt_r  <= '0;
      turn_tgt_r  <= '0;
      held_turn_r <= TURN_STRAIGHT;
      drawn_r     <= 1'b0;
    end else if (cmd.commit) begin
      avoid_rem_r <= avoid_rem_nxt;
      fwd_cnt_r   <= fwd_cnt_nxt;
      fwd_tgt_r   <= fwd_tgt_nxt;
      turn_cnt_r  <= turn_cnt_nxt;
      turn_tgt_r  <= turn_tgt_nxt;
      held_turn_r <= held_turn_nxt;
      drawn_r     <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) out_item_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
